/* rtl/core/rfs_pkg.sv */
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared types and constants of the ring fifo with search: opcodes, field
// widths, controller states and the command and status groups.
// ----------------------------------------------------------------------------
package rfs_pkg;

   localparam int DEPTH_DEF = 64;

   localparam int VALUE_W = 32;
   localparam int OP_W    = 3;
   localparam int CAP_W   = 7;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_ENQ    = 3'd0;
   localparam logic [OP_W-1:0] OP_DEQ    = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic start;     // latch request, clear pending result
      logic fail;      // pending status is failure
      logic enq;       // write at tail
      logic clr;       // empty the queue
      logic take;      // capture head word
      logic pop;       // remove head word
      logic scan_step; // advance scan pointer
      logic scan_hit;  // record match
      logic scan_miss; // record miss
      logic send;      // load output register
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic match;
      logic last;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/core/rfs_ram.sv */
// ----------------------------------------------------------------------------
// rfs_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module rfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/rfs_dp.sv */
// ----------------------------------------------------------------------------
// rfs_dp
// Datapath: pointers, occupancy, capacity register, storage ram, search
// scan pointer, pending result and output register.
// ----------------------------------------------------------------------------
module rfs_dp
   import rfs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            sts,
   input  logic [VALUE_W-1:0]       req_value,
   input  logic                     csr_we,
   input  logic [CAP_W-1:0]         csr_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [55:0]              rsp_payload
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int SX_W  = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;
   localparam int CX_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [PTR_W-1:0]   sp_ff, sp_in;
   logic [PTR_W-1:0]   spos_ff, spos_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               pst_ff, pst_in;
   logic [VALUE_W-1:0] pdata_ff, pdata_in;
   logic [PTR_W-1:0]   pslot_ff, pslot_in;
   logic [PTR_W-1:0]   ppos_ff, ppos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [55:0]        rsp_data_ff, rsp_data_in;

   logic [CMP_W-1:0]   cap_ext;
   logic [CNT_W-1:0]   cap_eff;
   logic [PTR_W-1:0]   rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic [SX_W-1:0]    slot_ext;
   logic [SX_W-1:0]    pos_ext;
   logic [CX_W-1:0]    cnt_ext;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] n;
      n = CNT_W'(p) + CNT_W'(1);
      return (n >= cap) ? '0 : n[PTR_W-1:0];
   endfunction

   // capacity clamped to 1..DEPTH
   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         cap_eff = CNT_W'(1);
      end else if (cap_ext > CMP_W'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = cap_ext[CNT_W-1:0];
      end
   end

   assign rd_addr = cmd.scan_step ? advance(sp_ff, cap_eff) : head_ff;

   rfs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.enq),
      .wr_addr (tail_ff),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sts.full     = (occ_ff >= cap_eff);
   assign sts.empty    = (occ_ff == '0);
   assign sts.match    = (rd_data == value_ff);
   assign sts.last     = ((CNT_W'(spos_ff) + CNT_W'(1)) >= occ_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign slot_ext = SX_W'(pslot_ff);
   assign pos_ext  = SX_W'(ppos_ff);
   assign cnt_ext  = CX_W'(occ_ff);

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      cap_in       = cap_ff;
      sp_in        = sp_ff;
      spos_in      = spos_ff;
      value_in     = value_ff;
      pst_in       = pst_ff;
      pdata_in     = pdata_ff;
      pslot_in     = pslot_ff;
      ppos_in      = ppos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.start) begin
         value_in = req_value;
         sp_in    = head_ff;
         spos_in  = '0;
         pst_in   = 1'b0;
         pdata_in = '0;
         pslot_in = '0;
         ppos_in  = '0;
      end
      if (cmd.fail) begin
         pst_in = 1'b1;
      end
      if (cmd.enq) begin
         tail_in = advance(tail_ff, cap_eff);
         occ_in  = occ_ff + CNT_W'(1);
      end
      if (cmd.clr) begin
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
      end
      if (cmd.take) begin
         pdata_in = rd_data;
      end
      if (cmd.pop) begin
         head_in = advance(head_ff, cap_eff);
         occ_in  = occ_ff - CNT_W'(1);
      end
      if (cmd.scan_step) begin
         sp_in   = advance(sp_ff, cap_eff);
         spos_in = spos_ff + PTR_W'(1);
      end
      if (cmd.scan_hit) begin
         pslot_in = sp_ff;
         ppos_in  = spos_ff;
      end
      if (cmd.scan_miss) begin
         pst_in = 1'b1;
      end

      if (cmd.send) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, sts.full, sts.empty, cnt_ext[COUNT_W-1:0],
                         pos_ext[SLOT_W-1:0], slot_ext[SLOT_W-1:0], pdata_ff, pst_ff};
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         cap_in  = csr_value;
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sp_ff       <= sp_in;
      spos_ff     <= spos_in;
      value_ff    <= value_in;
      pst_ff      <= pst_in;
      pdata_ff    <= pdata_in;
      pslot_ff    <= pslot_in;
      ppos_ff     <= ppos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

/* rtl/core/rfs_ctrl.sv */
// ----------------------------------------------------------------------------
// rfs_ctrl
// Controller: decodes the request opcode and sequences the datapath through
// head reads, the search scan and the result hand-off.
// ----------------------------------------------------------------------------
module rfs_ctrl
   import rfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [OP_W-1:0] req_op,
   input  dp_status_type   sts,
   output dp_cmd_type      cmd
);

   state_type       state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               state_in = ST_RESULT;
               case (req_op)
                  OP_DEQ, OP_PEEK: begin
                     if (!sts.empty) begin
                        state_in = ST_READ;
                     end
                  end
                  OP_SEARCH: begin
                     if (!sts.empty) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: state_in = ST_RESULT;
               endcase
            end
         end
         ST_READ: state_in = ST_RESULT;
         ST_SCAN: begin
            if (sts.match || sts.last) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               case (req_op)
                  OP_ENQ: begin
                     if (sts.full) begin
                        cmd.fail = 1'b1;
                     end else begin
                        cmd.enq = 1'b1;
                     end
                  end
                  OP_DEQ, OP_PEEK, OP_SEARCH: cmd.fail = sts.empty;
                  OP_CLEAR: cmd.clr = 1'b1;
                  default: cmd.fail = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            cmd.take = 1'b1;
            cmd.pop  = (op_ff == OP_DEQ);
         end
         ST_SCAN: begin
            if (sts.match) begin
               cmd.scan_hit = 1'b1;
            end else if (sts.last) begin
               cmd.scan_miss = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_RESULT: cmd.send = sts.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_ENQ;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

/* rtl/core/ring_fifo_with_search_top.sv */
// ----------------------------------------------------------------------------
// ring_fifo_with_search_top
// Circular fifo of signed 32-bit words with enqueue, dequeue, peek, clear
// and search operations.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream (opcode in tuser, word in tdata), one
// response per request leaves on the rsp_ stream. A request is taken only
// when the controller is idle. Enqueue, clear, failed and unknown operations
// go from idle straight to the result state; dequeue and peek pass through
// a read state first, for the registered read of the storage ram. A search
// reads one stored word per cycle from the head until it finds a match or
// reaches the last stored word. The next request may be accepted in the
// cycle after the response is loaded.
// The response sits in an output register; while the receiver stalls the
// controller holds its result and takes no new request beyond that one.
// The csr_ port writes the capacity register at any idle time; a write also
// empties the queue. Reset empties the queue and sets capacity to 64; the
// storage needs no clearing since a slot is read only after it was written.
// ----------------------------------------------------------------------------
module ring_fifo_with_search_top
   import rfs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,  // value[31:0]
   input  logic [OP_W-1:0]     req_tuser,  // opcode[2:0]
   // response stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [55:0]         rsp_tdata,  // status[0] data_out[32:1] slot_index[38:33]
                                           // position[44:39] count[51:45] empty_res[52]
                                           // full_res[53] zero[55:54]
   // capacity register write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAP_W-1:0]    csr_data
);

   dp_cmd_type    cmd;
   dp_status_type sts;

   assign csr_ready = 1'b1;

   rfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .sts       (sts),
      .cmd       (cmd)
   );

   rfs_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_value   (req_tdata),
      .csr_we      (csr_valid),
      .csr_value   (csr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_payload (rsp_tdata)
   );

endmodule
